// ----- src/wfc_pkg.sv -----
// Shared types, constants and character helpers for the word frequency counter.
`default_nettype none
package wfc_pkg;

    localparam int MAX_WORD_COUNT = 16;
    localparam int MAX_WORD_LEN   = 32;
    localparam int SLOT_W         = 4;
    localparam int POS_W          = 5;
    localparam int LEN_W          = 6;
    localparam int CNT_W          = 16;
    localparam int DIST_W         = 5;

    localparam logic [7:0] APOS = 8'h27;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic             append;
        logic             end_word;
        logic             commit_new;
        logic             clear;
        logic [7:0]       ch;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] wlen;
    } cell_cmd_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              is_new;
        logic [CNT_W-1:0]  occurrences;
        logic [LEN_W-1:0]  word_length;
        logic [DIST_W-1:0] distinct_total;
        logic [1:0]        status;
        logic              run_end;
    } res_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? (c + 8'h20) : c;
    endfunction

endpackage
`default_nettype wire

// ----- src/wfc_cell.sv -----
// One table slot: stored word text, length, count and running match flag.
`default_nettype none
module wfc_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire wfc_pkg::cell_cmd_t      cmd,
    input  wire logic                    occ_in,
    output logic                         occ_out,
    output logic                         hit,
    output logic [wfc_pkg::CNT_W-1:0]    count
);
    import wfc_pkg::*;

    logic [7:0]       text_reg [MAX_WORD_LEN];
    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] count_reg;
    logic             match_reg;
    logic             occupied;
    logic             free_slot;

    assign occupied  = (len_reg != '0);
    assign free_slot = occ_in && !occupied;
    assign occ_out   = occ_in && occupied;
    assign hit       = occupied && match_reg && (len_reg == cmd.wlen);
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            count_reg <= '0;
            match_reg <= 1'b0;
        end else if (cmd.clear) begin
            len_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.append) begin
                match_reg <= ((cmd.pos == '0) || match_reg) && (text_reg[cmd.pos] == cmd.ch);
            end
            if (cmd.end_word && hit && (count_reg != '1)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.end_word && cmd.commit_new && free_slot) begin
                len_reg   <= cmd.wlen;
                count_reg <= CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append && free_slot) begin
            text_reg[cmd.pos] <= cmd.ch;
        end
    end

    a_hit_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |-> occupied)
        else $error("hit on empty slot");
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !occupied |-> (count_reg == '0))
        else $error("empty slot holds a count");
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        occupied |-> occ_in)
        else $error("slot filled out of order");

endmodule
`default_nettype wire

// ----- src/word_frequency_counter_top.sv -----
// Top level: byte sequencer, row of table slot cells and result staging.
// Each byte is accepted in the idle state, then passes five sequencer steps (held
// apostrophe, current byte, flush, summary, final release) before the next ready,
// waiting while the result port stalls. Words are matched as they are built: every character
// is broadcast to the 16-cell slot row, each cell tracking a running compare, so a word
// end resolves in one step. Results of one byte leave in order, run_end on the last one.
`default_nettype none
module word_frequency_counter_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_char_in,
    input  wire logic                       s_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_kind,
    output logic [wfc_pkg::SLOT_W-1:0]      m_slot,
    output logic                            m_is_new,
    output logic [wfc_pkg::CNT_W-1:0]       m_occurrences,
    output logic [wfc_pkg::LEN_W-1:0]       m_word_length,
    output logic [wfc_pkg::DIST_W-1:0]      m_distinct_total,
    output logic [1:0]                      m_status,
    output logic                            m_run_end
);
    import wfc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_APOS  = 6'b000010,
        S_CHAR  = 6'b000100,
        S_FLUSH = 6'b001000,
        S_SUM   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        c_reg, c_next;
    logic              last_reg, last_next;
    logic              prev_reg, prev_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [1:0]        err_reg, err_next;
    res_t              stg_reg, stg_next;
    logic              stg_valid_reg, stg_valid_next;
    res_t              out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    cell_cmd_t                cmd;
    logic [MAX_WORD_COUNT:0]  occ_chain;
    logic [MAX_WORD_COUNT-1:0] hits;
    logic [CNT_W-1:0]         counts [MAX_WORD_COUNT];
    logic                     any_hit;
    logic [SLOT_W-1:0]        hit_idx;
    logic [CNT_W-1:0]         hit_cnt;
    logic [CNT_W-1:0]         inc_cnt;
    logic                     out_free;
    logic                     do_app, do_end, emit;
    logic [7:0]               app_ch;
    res_t                     ev;

    assign occ_chain[0] = 1'b1;

    for (genvar g = 0; g < MAX_WORD_COUNT; g++) begin : g_cell
        wfc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .occ_in  (occ_chain[g]),
            .occ_out (occ_chain[g+1]),
            .hit     (hits[g]),
            .count   (counts[g])
        );
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_WORD_COUNT; i++) begin
            if (hits[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign any_hit = |hits;
    assign hit_cnt = counts[hit_idx];
    assign inc_cnt = (hit_cnt == '1) ? hit_cnt : (hit_cnt + 1'b1);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        wlen_next      = wlen_reg;
        dist_next      = dist_reg;
        err_next       = err_reg;
        stg_next       = stg_reg;
        stg_valid_next = stg_valid_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        cmd.wlen       = wlen_reg;
        do_app         = 1'b0;
        do_end         = 1'b0;
        emit           = 1'b0;
        app_ch         = APOS;
        ev             = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    c_next     = s_char_in;
                    last_next  = s_last;
                    state_next = S_APOS;
                end
            end
            S_APOS: begin
                if (out_free) begin
                    state_next = S_CHAR;
                    if ((err_reg == ST_OK) && pend_reg) begin
                        pend_next = 1'b0;
                        if (is_alpha(c_reg)) begin
                            do_app = 1'b1;
                            app_ch = APOS;
                        end else begin
                            do_end    = 1'b1;
                            prev_next = 1'b0;
                        end
                    end
                end
            end
            S_CHAR: begin
                if (out_free) begin
                    state_next = S_FLUSH;
                    if (err_reg == ST_OK) begin
                        if ((c_reg == APOS) && prev_reg && !last_reg) begin
                            pend_next = 1'b1;
                        end else if (is_alnum(c_reg)) begin
                            do_app    = 1'b1;
                            app_ch    = to_lower(c_reg);
                            prev_next = 1'b1;
                        end else begin
                            do_end    = prev_reg;
                            prev_next = 1'b0;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    state_next = S_SUM;
                    do_end     = last_reg && (err_reg == ST_OK);
                end
            end
            S_SUM: begin
                if (out_free) begin
                    state_next = S_DONE;
                    if (last_reg) begin
                        emit              = 1'b1;
                        ev.kind           = KIND_SUMMARY;
                        ev.distinct_total = dist_reg;
                        ev.status         = err_reg;
                        cmd.clear         = 1'b1;
                        prev_next         = 1'b0;
                        pend_next         = 1'b0;
                        wlen_next         = '0;
                        dist_next         = '0;
                        err_next          = ST_OK;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (stg_valid_reg) begin
                        out_next         = stg_reg;
                        out_next.run_end = 1'b1;
                        m_valid_next     = 1'b1;
                        stg_valid_next   = 1'b0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_app) begin
            if (wlen_reg == LEN_W'(MAX_WORD_LEN)) begin
                err_next = ST_TOO_LONG;
            end else begin
                cmd.append = 1'b1;
                cmd.ch     = app_ch;
                cmd.pos    = wlen_reg[POS_W-1:0];
                wlen_next  = wlen_reg + 1'b1;
            end
        end

        if (do_end && (wlen_reg != '0)) begin
            wlen_next    = '0;
            cmd.end_word = 1'b1;
            if (any_hit) begin
                emit              = 1'b1;
                ev.kind           = KIND_WORD;
                ev.slot           = hit_idx;
                ev.is_new         = 1'b0;
                ev.occurrences    = inc_cnt;
                ev.word_length    = wlen_reg;
                ev.distinct_total = dist_reg;
                ev.status         = ST_OK;
            end else if (dist_reg >= DIST_W'(MAX_WORD_COUNT)) begin
                err_next = ST_TOO_MANY;
            end else begin
                cmd.commit_new    = 1'b1;
                dist_next         = dist_reg + 1'b1;
                emit              = 1'b1;
                ev.kind           = KIND_WORD;
                ev.slot           = dist_reg[SLOT_W-1:0];
                ev.is_new         = 1'b1;
                ev.occurrences    = CNT_W'(1);
                ev.word_length    = wlen_reg;
                ev.distinct_total = dist_reg + 1'b1;
                ev.status         = ST_OK;
            end
        end

        if (emit) begin
            if (stg_valid_reg) begin
                out_next         = stg_reg;
                out_next.run_end = 1'b0;
                m_valid_next     = 1'b1;
            end
            stg_next       = ev;
            stg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            wlen_reg      <= '0;
            dist_reg      <= '0;
            err_reg       <= ST_OK;
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            pend_reg      <= pend_next;
            wlen_reg      <= wlen_next;
            dist_reg      <= dist_next;
            err_reg       <= err_next;
            stg_valid_reg <= stg_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg    <= c_next;
        last_reg <= last_next;
        stg_reg  <= stg_next;
        out_reg  <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_slot           = out_reg.slot;
    assign m_is_new         = out_reg.is_new;
    assign m_occurrences    = out_reg.occurrences;
    assign m_word_length    = out_reg.word_length;
    assign m_distinct_total = out_reg.distinct_total;
    assign m_status         = out_reg.status;
    assign m_run_end        = out_reg.run_end;

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hits))
        else $error("word matched in two slots");
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_reg <= DIST_W'(MAX_WORD_COUNT))
        else $error("distinct count out of range");
    a_wlen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wlen_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("word length out of range");
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != 2'd3)
        else $error("bad error code");
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !stg_valid_reg)
        else $error("staged result left behind");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for word_frequency_counter_top: directed and random sentences checked against a word table predictor.
`timescale 1ns / 1ps
module tb_top;
    import wfc_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              is_new;
        logic [CNT_W-1:0]  occurrences;
        logic [LEN_W-1:0]  word_length;
        logic [DIST_W-1:0] distinct_total;
        logic [1:0]        status;
        logic              run_end;
    } wfc_result_t;

    class word_scoreboard;
        wfc_result_t pending_q[$];
        int          errors;
        bit          prev_word;
        bit          held_apos;
        byte         cur_word[$];
        byte         words[MAX_WORD_COUNT][$];
        int          counts[MAX_WORD_COUNT];
        int          n_distinct;
        logic [1:0]  err;

        function void clear_sentence();
            prev_word  = 0;
            held_apos  = 0;
            cur_word   = {};
            n_distinct = 0;
            err        = ST_OK;
            for (int i = 0; i < MAX_WORD_COUNT; i++) begin
                words[i]  = {};
                counts[i] = 0;
            end
        endfunction

        function void push(logic k, int s, logic nw, int occ, int len, logic [1:0] st,
                           ref wfc_result_t q[$]);
            wfc_result_t r;
            r.kind = k; r.slot = SLOT_W'(s); r.is_new = nw; r.occurrences = CNT_W'(occ);
            r.word_length = LEN_W'(len); r.distinct_total = DIST_W'(n_distinct);
            r.status = st;
            r.run_end = 0;
            q.push_back(r);
        endfunction

        function void add_char(byte c);
            if (cur_word.size() >= MAX_WORD_LEN) err = ST_TOO_LONG;
            else cur_word.push_back(c);
        endfunction

        function void close_word(ref wfc_result_t q[$]);
            int len;
            len = cur_word.size();
            if (len == 0) return;
            for (int s = 0; s < n_distinct; s++) begin
                if (words[s] == cur_word) begin
                    if (counts[s] < 65535) counts[s]++;
                    push(KIND_WORD, s, 0, counts[s], len, ST_OK, q);
                    cur_word = {};
                    return;
                end
            end
            if (n_distinct >= MAX_WORD_COUNT) begin
                err = ST_TOO_MANY;
                cur_word = {};
                return;
            end
            words[n_distinct]  = cur_word;
            counts[n_distinct] = 1;
            n_distinct++;
            push(KIND_WORD, n_distinct - 1, 1, 1, len, ST_OK, q);
            cur_word = {};
        endfunction

        function void note_input(logic [7:0] c, logic last);
            wfc_result_t q[$];
            if (err == ST_OK) begin
                if (held_apos) begin
                    held_apos = 0;
                    if (is_alpha(c)) add_char(APOS);
                    else begin
                        close_word(q);
                        prev_word = 0;
                    end
                end
                if (err == ST_OK) begin
                    if (c == APOS && prev_word && !last) held_apos = 1;
                    else if (is_alnum(c)) begin
                        add_char((c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c);
                        prev_word = 1;
                    end else begin
                        if (prev_word) close_word(q);
                        prev_word = 0;
                    end
                end
                if (last && err == ST_OK) close_word(q);
            end
            if (last) begin
                push(KIND_SUMMARY, 0, 0, 0, 0, err, q);
                clear_sentence();
            end
            if (q.size() > 0) q[q.size()-1].run_end = 1;
            foreach (q[i]) pending_q.push_back(q[i]);
        endfunction

        function void check_result(wfc_result_t a);
            wfc_result_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d slot=%0d", $time, a.kind, a.slot);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (e != a) begin
                $display("%0t: mismatch exp k=%0d s=%0d n=%0d o=%0d l=%0d d=%0d st=%0d e=%0d",
                         $time, e.kind, e.slot, e.is_new, e.occurrences, e.word_length,
                         e.distinct_total, e.status, e.run_end);
                $display("%0t:          act k=%0d s=%0d n=%0d o=%0d l=%0d d=%0d st=%0d e=%0d",
                         $time, a.kind, a.slot, a.is_new, a.occurrences, a.word_length,
                         a.distinct_total, a.status, a.run_end);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [7:0] s_char_in = 0;
    logic s_last = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_kind, m_is_new, m_run_end;
    logic [SLOT_W-1:0] m_slot;
    logic [CNT_W-1:0] m_occurrences;
    logic [LEN_W-1:0] m_word_length;
    logic [DIST_W-1:0] m_distinct_total;
    logic [1:0] m_status;

    word_frequency_counter_top dut (.*);

    always #4 aclk = ~aclk;

    word_scoreboard sb = new();
    int src_idle_pct;
    int sink_idle_pct;
    bit hold_sink;
    int n_cycles;

    task automatic send_byte(logic [7:0] c, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid   <= 1;
        s_char_in <= c;
        s_last    <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(c, last);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i], i == t.len() - 1);
    endtask

    function automatic byte pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 50) return byte'(8'h61 + $urandom_range(3));
        if (r < 60) return byte'(8'h41 + $urandom_range(3));
        if (r < 65) return byte'(8'h30 + $urandom_range(9));
        if (r < 75) return APOS;
        if (r < 92) return 8'h20;
        return byte'($urandom_range(255));
    endfunction

    task automatic random_sentence(int n);
        for (int i = 0; i < n; i++) send_byte(pick_char(), i == n - 1);
    endtask

    always @(posedge aclk) begin
        wfc_result_t a;
        if (aresetn && m_valid && m_ready) begin
            a.kind = m_kind; a.slot = m_slot; a.is_new = m_is_new;
            a.occurrences = m_occurrences; a.word_length = m_word_length;
            a.distinct_total = m_distinct_total; a.status = m_status; a.run_end = m_run_end;
            sb.check_result(a);
        end
        m_ready <= !hold_sink && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 400000) begin
            $display("word_frequency_counter_top verification failed");
            $finish;
        end
    end

    initial begin
        n_cycles = 0;
        hold_sink = 0;
        sb.errors = 0;
        sb.clear_sentence();
        src_idle_pct = 6;
        sink_idle_pct = 53;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed
        send_text("Don't stop 'x' it's AB9 ab9 z'");
        send_text({"a b c d e f g h i j k l m n o p ", "q a"});
        send_text({"abcdefghijklmnopqrstuvwxyz0123456 ", "ok"});
        send_byte(8'hFF, 1);
        send_byte(APOS, 1);
        send_text("zz' 9Z\x80x");
        // long sink hold with sender pushing
        hold_sink = 1;
        fork
            begin random_sentence(12); s_valid <= 0; end
            begin repeat (300) @(posedge aclk); hold_sink = 0; end
        join
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 53 : 0;
            sink_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 6 : 0;
            for (int k = 0; k < 2; k++) random_sentence($urandom_range(3, 8));
        end
        s_valid <= 0;
        while (sb.pending_q.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("word_frequency_counter_top verification clean");
        else
            $display("word_frequency_counter_top verification failed");
        $finish;
    end
endmodule

// ----- files.f -----
src/wfc_pkg.sv
src/wfc_cell.sv
src/word_frequency_counter_top.sv
tb/tb_top.sv
